[src/cfcp_pkg.sv]
package cfcp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes, valid when the kind is an error.
  localparam logic [1:0] ERR_MAGIC   = 2'd0;
  localparam logic [1:0] ERR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_TAG     = 2'd2;

  // Width of the byte_offset field on the result channel.
  localparam int OFFSET_FIELD_W = 32;

  typedef struct packed {
    logic [1:0]                kind;
    logic [1:0]                error_code;
    logic [15:0]               slot_index;
    logic [7:0]                entry_tag;
    logic [OFFSET_FIELD_W-1:0] byte_offset;
    logic [16:0]               entry_size;
    logic [15:0]               ref_first;
    logic [15:0]               ref_second;
    logic [63:0]               raw_value;
    logic                      run_end;
  } result_t;

  // Everything one input byte produces. The optional second result is
  // always a pool end or a truncation error, so only its offset and kind bit are kept.
  typedef struct packed {
    result_t                   primary;
    logic                      has_second;
    logic                      second_end;
    logic [OFFSET_FIELD_W-1:0] second_offset;
  } bundle_t;

endpackage

[src/cfcp_if.sv]
interface cfcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfcp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [15:0] slot_index;
  logic [7:0]  entry_tag;
  logic [31:0] byte_offset;
  logic [16:0] entry_size;
  logic [15:0] ref_first;
  logic [15:0] ref_second;
  logic [63:0] raw_value;
  logic        run_end;

  modport source (output valid, output kind, output error_code, output slot_index,
                  output entry_tag, output byte_offset, output entry_size,
                  output ref_first, output ref_second, output raw_value,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input error_code, input slot_index,
                  input entry_tag, input byte_offset, input entry_size,
                  input ref_first, input ref_second, input raw_value,
                  input run_end, output ready);
endinterface

[src/class_file_constant_pool_parser_core.sv]
// Channel  Dir  Contents
// stream   in   data_byte (8), last_byte (1): one class file byte per transfer
// report   out  kind, error_code, slot_index, entry_tag, byte_offset, entry_size,
//               ref_first, ref_second, raw_value, run_end: one result per transfer
//
// The parser takes one byte every cycle while the queue has room; its state
// update is a field-counting state machine. A byte makes at most two results,
// and the output register sends one result per cycle while report.ready is high;
// a byte with two results holds it while the two-entry queue keeps bytes coming.
// Reset is synchronous; there is no clearing pass.
// Either side may stall at any time: the queue fills and stream.ready drops.
module class_file_constant_pool_parser_core
  import cfcp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  cfcp_byte_if.sink     stream,
  cfcp_result_if.source report
);

  // The front parser classifies each byte and packs everything it causes
  // into one bundle. The bundle queue decouples it from the back end, which
  // unrolls each bundle into one or two result transfers.
  logic    fifo_push;
  logic    fifo_full;
  logic    fifo_pop;
  logic    fifo_valid;
  bundle_t front_bundle;
  bundle_t head_bundle;

  cfcp_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .full   (fifo_full),
    .push   (fifo_push),
    .bundle (front_bundle)
  );

  cfcp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fifo_push),
    .wr_data  (front_bundle),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .rd_valid (fifo_valid),
    .rd_data  (head_bundle)
  );

  cfcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (fifo_valid),
    .head       (head_bundle),
    .pop        (fifo_pop),
    .report     (report)
  );

`ifndef SYNTHESIS
  // The parser must never produce a bundle the queue cannot hold.
  assert property (@(posedge clk) disable iff (rst) fifo_push |-> !fifo_full)
    else $error("bundle pushed into a full queue");

  // A result that is not the last of its byte is followed at once by the
  // trailing pool end or truncation error.
  assert property (@(posedge clk) disable iff (rst)
      report.valid && report.ready && !report.run_end
      |=> report.valid && (report.kind == KIND_END || report.kind == KIND_ERROR))
    else $error("trailing result missing after a non-final result");

  // An error always closes the run of results for its byte.
  assert property (@(posedge clk) disable iff (rst)
      report.valid && report.kind == KIND_ERROR |-> report.run_end)
    else $error("error result without run_end");
`endif

endmodule

[src/cfcp_front.sv]
module cfcp_front
  import cfcp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  cfcp_byte_if.sink   stream,
  input  logic        full,
  output logic        push,
  output bundle_t     bundle
);

  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_VERSION = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_TAG     = 3'd3;
  localparam logic [2:0] PH_BODY    = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  localparam logic [7:0] TAG_UTF8    = 8'd1;
  localparam logic [7:0] TAG_INT     = 8'd3;
  localparam logic [7:0] TAG_FLOAT   = 8'd4;
  localparam logic [7:0] TAG_LONG    = 8'd5;
  localparam logic [7:0] TAG_DOUBLE  = 8'd6;
  localparam logic [7:0] TAG_CLASS   = 8'd7;
  localparam logic [7:0] TAG_STRING  = 8'd8;
  localparam logic [7:0] TAG_FIELD   = 8'd9;
  localparam logic [7:0] TAG_METHOD  = 8'd10;
  localparam logic [7:0] TAG_IMETHOD = 8'd11;
  localparam logic [7:0] TAG_NTYPE   = 8'd12;
  localparam logic [7:0] TAG_MHANDLE = 8'd15;
  localparam logic [7:0] TAG_MTYPE   = 8'd16;
  localparam logic [7:0] TAG_INDY    = 8'd18;

  localparam logic [31:0] MAGIC = 32'hCAFE_BABE;

  // Entry size from the tag; zero flags an unknown tag. Utf8 starts at
  // three and grows once its length field is in.
  function automatic logic [16:0] tag_size(input logic [7:0] t);
    logic [16:0] s;
    s = 17'd0;
    unique case (t) inside
      TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_MTYPE: s = 17'd3;
      TAG_MHANDLE: s = 17'd4;
      TAG_INT, TAG_FLOAT, TAG_FIELD, TAG_METHOD, TAG_IMETHOD, TAG_NTYPE, TAG_INDY:
        s = 17'd5;
      TAG_LONG, TAG_DOUBLE: s = 17'd9;
      default: s = 17'd0;
    endcase
    return s;
  endfunction

  logic [2:0]             phase, phase_next;
  logic [16:0]            field_byte_count, field_byte_count_next;
  logic [OFFSET_BITS-1:0] stream_offset;
  logic [16:0]            current_slot, current_slot_next;
  logic [15:0]            pool_count, pool_count_next;
  logic [7:0]             current_tag, current_tag_next;
  logic [16:0]            current_size, current_size_next;
  logic [OFFSET_BITS-1:0] entry_start, entry_start_next;
  logic [63:0]            value_shift, value_shift_next;
  logic [15:0]            first_ref, first_ref_next;
  logic [15:0]            second_ref, second_ref_next;

  logic                   accept;
  logic [OFFSET_BITS-1:0] offset_plus;
  logic [7:0]             b;
  logic                   prim_valid, end_valid, trunc_valid;
  result_t                prim;

  assign stream.ready = !full;
  assign accept       = stream.valid && !full;
  assign b            = stream.data_byte;
  assign offset_plus  = stream_offset + OFFSET_BITS'(1);

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    current_slot_next     = current_slot;
    pool_count_next       = pool_count;
    current_tag_next      = current_tag;
    current_size_next     = current_size;
    entry_start_next      = entry_start;
    value_shift_next      = value_shift;
    first_ref_next        = first_ref;
    second_ref_next       = second_ref;
    prim_valid            = 1'b0;
    end_valid             = 1'b0;
    prim                  = '0;

    unique case (phase)
      PH_MAGIC: begin
        value_shift_next      = {32'd0, value_shift[23:0], b};
        field_byte_count_next = field_byte_count + 17'd1;
        if (field_byte_count_next >= 17'd4) begin
          if (value_shift_next[31:0] != MAGIC) begin
            prim_valid      = 1'b1;
            prim.kind       = KIND_ERROR;
            prim.error_code = ERR_MAGIC;
            phase_next      = PH_DONE;
          end else begin
            phase_next            = PH_VERSION;
            field_byte_count_next = 17'd0;
            value_shift_next      = 64'd0;
          end
        end
      end
      PH_VERSION: begin
        // Minor version comes first, then major.
        if (field_byte_count < 17'd2) begin
          second_ref_next = {second_ref[7:0], b};
        end else begin
          first_ref_next = {first_ref[7:0], b};
        end
        field_byte_count_next = field_byte_count + 17'd1;
        if (field_byte_count_next >= 17'd4) begin
          phase_next            = PH_COUNT;
          field_byte_count_next = 17'd0;
        end
      end
      PH_COUNT: begin
        pool_count_next       = {pool_count[7:0], b};
        field_byte_count_next = field_byte_count + 17'd1;
        if (field_byte_count_next >= 17'd2) begin
          prim_valid            = 1'b1;
          prim.kind             = KIND_HEADER;
          prim.ref_first        = first_ref;
          prim.ref_second       = second_ref;
          prim.raw_value        = 64'(pool_count_next);
          field_byte_count_next = 17'd0;
          if (current_slot >= {1'b0, pool_count_next}) begin
            end_valid  = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        current_tag_next      = b;
        entry_start_next      = stream_offset;
        value_shift_next      = 64'd0;
        field_byte_count_next = 17'd1;
        current_size_next     = tag_size(b);
        if (current_size_next == 17'd0) begin
          prim_valid       = 1'b1;
          prim.kind        = KIND_ERROR;
          prim.error_code  = ERR_TAG;
          prim.entry_tag   = b;
          prim.byte_offset = OFFSET_FIELD_W'(stream_offset);
          phase_next       = PH_DONE;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        value_shift_next      = {value_shift[55:0], b};
        field_byte_count_next = field_byte_count + 17'd1;
        if (current_tag == TAG_UTF8 && field_byte_count_next == 17'd3) begin
          current_size_next = 17'd3 + 17'(value_shift_next[15:0]);
        end
        if (field_byte_count_next >= current_size_next) begin
          prim_valid       = 1'b1;
          prim.kind        = KIND_ENTRY;
          prim.slot_index  = current_slot[15:0];
          prim.entry_tag   = current_tag;
          prim.byte_offset = OFFSET_FIELD_W'(entry_start);
          prim.entry_size  = current_size_next;
          case (current_tag) inside
            TAG_CLASS, TAG_STRING, TAG_MTYPE: prim.ref_first = value_shift_next[15:0];
            TAG_MHANDLE: begin
              prim.ref_first  = {8'd0, value_shift_next[23:16]};
              prim.ref_second = value_shift_next[15:0];
            end
            TAG_FIELD, TAG_METHOD, TAG_IMETHOD, TAG_NTYPE, TAG_INDY: begin
              prim.ref_first  = value_shift_next[31:16];
              prim.ref_second = value_shift_next[15:0];
            end
            TAG_INT, TAG_FLOAT: prim.raw_value = {32'd0, value_shift_next[31:0]};
            TAG_LONG, TAG_DOUBLE: prim.raw_value = value_shift_next;
            default: prim.raw_value = 64'd0;
          endcase
          if (current_tag == TAG_LONG || current_tag == TAG_DOUBLE) begin
            current_slot_next = current_slot + 17'd2;
          end else begin
            current_slot_next = current_slot + 17'd1;
          end
          field_byte_count_next = 17'd0;
          if (current_slot_next >= {1'b0, pool_count}) begin
            end_valid  = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_TAG;
          end
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    trunc_valid = stream.last_byte && (phase_next != PH_DONE);

    bundle = '0;
    if (prim_valid) begin
      bundle.primary       = prim;
      bundle.has_second    = end_valid || trunc_valid;
      bundle.second_end    = end_valid;
      bundle.second_offset = OFFSET_FIELD_W'(offset_plus);
    end else begin
      bundle.primary.kind        = KIND_ERROR;
      bundle.primary.error_code  = ERR_TRUNC;
      bundle.primary.byte_offset = OFFSET_FIELD_W'(offset_plus);
    end
    bundle.primary.run_end = !bundle.has_second;

    // The last byte of a chunk starts the next class file from scratch.
    if (stream.last_byte) begin
      phase_next            = PH_MAGIC;
      field_byte_count_next = 17'd0;
      current_slot_next     = 17'd1;
      pool_count_next       = 16'd0;
      current_tag_next      = 8'd0;
      current_size_next     = 17'd0;
      entry_start_next      = '0;
      value_shift_next      = 64'd0;
      first_ref_next        = 16'd0;
      second_ref_next       = 16'd0;
    end
  end

  assign push = accept && (prim_valid || trunc_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_MAGIC;
      field_byte_count <= 17'd0;
      stream_offset    <= '0;
      current_slot     <= 17'd1;
      pool_count       <= 16'd0;
      current_tag      <= 8'd0;
      current_size     <= 17'd0;
      entry_start      <= '0;
      value_shift      <= 64'd0;
      first_ref        <= 16'd0;
      second_ref       <= 16'd0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      stream_offset    <= stream.last_byte ? '0 : offset_plus;
      current_slot     <= current_slot_next;
      pool_count       <= pool_count_next;
      current_tag      <= current_tag_next;
      current_size     <= current_size_next;
      entry_start      <= entry_start_next;
      value_shift      <= value_shift_next;
      first_ref        <= first_ref_next;
      second_ref       <= second_ref_next;
    end
  end

endmodule

[src/cfcp_fifo.sv]
module cfcp_fifo
  import cfcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    pop,
  output logic    rd_valid,
  output bundle_t rd_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/cfcp_back.sv]
module cfcp_back
  import cfcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  bundle_t      head,
  output logic         pop,
  cfcp_result_if.source report
);

  logic    out_valid;
  result_t out_res;
  logic    second_pending;
  logic    load;
  result_t second_res;

  // Expand the short form of the trailing result.
  always_comb begin
    second_res             = '0;
    second_res.kind        = head.second_end ? KIND_END : KIND_ERROR;
    second_res.error_code  = head.second_end ? ERR_MAGIC : ERR_TRUNC;
    second_res.byte_offset = head.second_offset;
    second_res.run_end     = 1'b1;
  end

  assign load = head_valid && (!out_valid || report.ready);
  assign pop  = load && (second_pending || !head.has_second);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      out_valid      <= 1'b1;
      second_pending <= !second_pending && head.has_second;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= second_pending ? second_res : head.primary;
    end
  end

  assign report.valid       = out_valid;
  assign report.kind        = out_res.kind;
  assign report.error_code  = out_res.error_code;
  assign report.slot_index  = out_res.slot_index;
  assign report.entry_tag   = out_res.entry_tag;
  assign report.byte_offset = out_res.byte_offset;
  assign report.entry_size  = out_res.entry_size;
  assign report.ref_first   = out_res.ref_first;
  assign report.ref_second  = out_res.ref_second;
  assign report.raw_value   = out_res.raw_value;
  assign report.run_end     = out_res.run_end;

endmodule
